// ===== rtl/mbp_pkg.sv =====
// Package: widths, codes and the job record shared by the bit packer modules.
package mbp_pkg;

  // Code size limit and byte geometry
  localparam int MAX_CODE_BITS = 32;
  localparam int BYTE_BITS     = 8;
  localparam int PEND_W        = BYTE_BITS - 1;
  localparam int PC_W          = $clog2(BYTE_BITS);

  // Accumulator: pending bits plus the longest code
  localparam int ACC_W     = MAX_CODE_BITS + PEND_W;
  localparam int TOT_W     = $clog2(ACC_W + 1);
  localparam int MAX_BYTES = (PEND_W + MAX_CODE_BITS) / BYTE_BITS;
  localparam int NB_W      = $clog2(MAX_BYTES + 1);

  // Stream field widths
  localparam int LEN_FIELD_W = 6;
  localparam int VALUE_W     = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item kinds carried in tuser
  typedef enum logic {
    FUNC_PUT   = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  // One job: stream bits left aligned, first byte in the top bits
  typedef struct packed {
    logic [ACC_W-1:0] word;
    logic [NB_W-1:0]  nbytes;
  } job_t;

endpackage

// ===== rtl/mbp_front.sv =====
// Front end: takes input beats, merges codes with the pending bits, builds byte jobs.
module mbp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: code_length [5:0], code_value [37:6], zero [39:38]
  input  logic [mbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: func [0]
  input  logic                            s_axis_tuser_i,
  input  logic                            queue_full_i,
  output logic                            push_o,
  output mbp_pkg::job_t                   push_job_o
);
  import mbp_pkg::*;

  logic [PEND_W-1:0]      pend_q, pend_d;
  logic [PC_W-1:0]        pc_q, pc_d;
  logic                   accept;
  logic                   is_flush;
  logic [LEN_FIELD_W-1:0] len_in;
  logic [VALUE_W-1:0]     val_in;
  logic [TOT_W-1:0]       len_sat;
  logic [ACC_W-1:0]       val_m;
  logic [ACC_W-1:0]       acc;
  logic [TOT_W-1:0]       total;
  logic [ACC_W-1:0]       sh_src;
  logic [TOT_W-1:0]       sh_tot;
  logic [NB_W-1:0]        nbytes;

  assign accept   = s_axis_tvalid_i & s_axis_tready_o;
  assign is_flush = (s_axis_tuser_i == FUNC_FLUSH);
  assign len_in   = s_axis_tdata_i[LEN_FIELD_W-1:0];
  assign val_in   = s_axis_tdata_i[LEN_FIELD_W +: VALUE_W];

  // Room for a job is always required, so the queue never overflows
  assign s_axis_tready_o = ~queue_full_i;

  // Put path: saturate length, mask the value, append after pending bits
  always_comb begin
    len_sat = (len_in > LEN_FIELD_W'(MAX_CODE_BITS)) ? TOT_W'(MAX_CODE_BITS)
                                                     : TOT_W'(len_in);
    val_m   = ACC_W'(val_in) & ~({ACC_W{1'b1}} << len_sat);
    acc     = (ACC_W'(pend_q) << len_sat) | val_m;
    total   = TOT_W'(pc_q) + len_sat;
  end

  // Job build: flush treats the pending bits alone as the stream
  always_comb begin
    if (is_flush) begin
      sh_src = ACC_W'(pend_q);
      sh_tot = TOT_W'(pc_q);
      nbytes = NB_W'(pc_q != '0);
      pend_d = '0;
      pc_d   = '0;
    end else begin
      sh_src = acc;
      sh_tot = total;
      nbytes = NB_W'(total >> PC_W);
      pc_d   = total[PC_W-1:0];
      pend_d = PEND_W'(acc & ~({ACC_W{1'b1}} << pc_d));
    end
    push_job_o.word   = sh_src << (TOT_W'(ACC_W) - sh_tot);
    push_job_o.nbytes = nbytes;
  end

  assign push_o = accept & (nbytes != '0);

  // Pending state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pc_q   <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      pc_q   <= pc_d;
    end
  end

endmodule

// ===== rtl/mbp_queue.sv =====
// Job queue: small register FIFO between the front and the byte emitter.
module mbp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbp_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mbp_pkg::job_t head_job_o
);
  import mbp_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign head_job_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from an empty queue");

endmodule

// ===== rtl/mbp_back.sv =====
// Back end: unpacks jobs into byte beats through an output register.
module mbp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  mbp_pkg::job_t                   job_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: out_byte [7:0]
  output logic [mbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);
  import mbp_pkg::*;

  logic [ACC_W-1:0] word_q;
  logic [NB_W-1:0]  cnt_q;
  logic             busy_q;
  logic             out_valid_q;
  logic [BYTE_BITS-1:0] out_byte_q;
  logic             out_last_q;
  logic             adv;
  logic             emit;
  logic             load;
  logic             final_byte;

  assign adv        = ~out_valid_q | m_axis_tready_i;
  assign emit       = busy_q & adv;
  assign final_byte = (cnt_q == NB_W'(1));
  assign load       = job_valid_i & (~busy_q | (emit & final_byte));
  assign pop_o      = load;

  // Control: byte count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        cnt_q  <= job_i.nbytes;
      end else if (emit) begin
        busy_q <= ~final_byte;
        cnt_q  <= cnt_q - 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (adv) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: shift word, capture top byte
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= job_i.word;
    end else if (emit) begin
      word_q <= word_q << BYTE_BITS;
    end
    if (emit) begin
      out_byte_q <= word_q[ACC_W-1 -: BYTE_BITS];
      out_last_q <= final_byte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_byte_q);
  assign m_axis_tlast_o  = out_last_q;

  a_busy_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("emitter busy with no bytes left");

  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> job_i.nbytes != '0)
    else $error("empty job reached the emitter");

endmodule

// ===== rtl/msb_first_bit_packer_top.sv =====
// Path: an accepted beat that completes bytes is written to the job queue, loaded into the
// emitter, then its first byte is registered in the output register.
// Throughput: one input beat per cycle while the queue has room; the emitter drains one
// byte a cycle while the receiver is ready, and a put completes 0 to 4 bytes.
// Reset: asynchronous active low; clears pending bits, queue and output valid.
// Top level: MSB-first bit packer, front end, job queue and byte emitter.
module msb_first_bit_packer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: code_length [5:0], code_value [37:6], zero [39:38]
  input  logic [mbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: func [0]
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: out_byte [7:0]
  output logic [mbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);
  import mbp_pkg::*;

  logic push;
  job_t push_job;
  logic queue_full;
  logic pop;
  logic queue_empty;
  job_t head_job;

  mbp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .push_job_o      (push_job)
  );

  mbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (queue_full),
    .pop_i      (pop),
    .empty_o    (queue_empty),
    .head_job_o (head_job)
  );

  mbp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (~queue_empty),
    .job_i           (head_job),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== verif/mbp_stream_checker.sv =====
// Stream checker for the MSB-first bit packer: predicts the byte stream and compares each beat.
module mbp_stream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // tdata: code_length [5:0], code_value [37:6], zero [39:38]
  input  logic [mbp_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  // tuser: func [0]
  input  logic                            s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // tdata: out_byte [7:0]
  input  logic [mbp_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                            m_tlast_i,
  output int                              fail_count_o,
  output int                              bytes_waiting_o,
  output int                              bytes_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbp_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  // Bytes the stream still owes us, oldest first
  byte_beat_t want_bytes_q[$];
  byte_beat_t got_byte;

  // Our own copy of the partial byte: bits right aligned, oldest bit highest
  logic [6:0] tail_bits;
  logic [2:0] tail_cnt;

  // Append one code (or flush) to the predicted stream
  task automatic pack_code(input func_e func, input logic [5:0] len_in,
                           input logic [31:0] val);
    logic [63:0] acc;
    int          len;
    int          total;
    int          nb;
    byte_beat_t  bb;
    if (func == FUNC_FLUSH) begin
      // pad the partial byte with zeros; nothing on a byte boundary
      if (tail_cnt != 3'd0) begin
        bb.data = 8'({57'd0, tail_bits} << (BYTE_BITS - int'(tail_cnt)));
        bb.last = 1'b1;
        want_bytes_q.push_back(bb);
      end
      tail_bits = '0;
      tail_cnt  = '0;
    end else begin
      // lengths above the limit saturate
      len = (int'(len_in) > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(len_in);
      if (len != 0) begin
        acc   = ({57'd0, tail_bits} << len) | ({32'd0, val} & ((64'd1 << len) - 64'd1));
        total = int'(tail_cnt) + len;
        nb    = 0;
        while (total >= BYTE_BITS) begin
          total   = total - BYTE_BITS;
          bb.data = 8'(acc >> total);
          bb.last = 1'b0;
          want_bytes_q.push_back(bb);
          nb++;
        end
        if (nb > 0) want_bytes_q[want_bytes_q.size()-1].last = 1'b1;
        tail_cnt  = 3'(total);
        tail_bits = 7'(acc & ((64'd1 << total) - 64'd1));
      end
    end
  endtask

  // Watch both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_bits = '0;
      tail_cnt  = '0;
      want_bytes_q.delete();
      fail_count_o    = 0;
      bytes_waiting_o = 0;
      bytes_seen_o    = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        pack_code(func_e'(s_tuser_i), s_tdata_i[5:0], s_tdata_i[37:6]);
      end
      if (m_tvalid_i && m_tready_i) begin
        bytes_seen_o++;
        if (want_bytes_q.size() == 0) begin
          $error("unexpected output beat: out_byte %02h last %0b", m_tdata_i, m_tlast_i);
          fail_count_o++;
        end else begin
          got_byte = want_bytes_q.pop_front();
          if (m_tdata_i !== got_byte.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", got_byte.data, m_tdata_i);
            fail_count_o++;
          end
          if (m_tlast_i !== got_byte.last) begin
            $error("last mismatch: expected %0b, actual %0b", got_byte.last, m_tlast_i);
            fail_count_o++;
          end
        end
      end
      bytes_waiting_o = want_bytes_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the MSB-first bit packer: clock, reset, code stimulus, receiver stalls, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbp_pkg::*;

  localparam int N_RANDOM    = 270;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    func_e       func;
    logic [5:0]  len;
    logic [31:0] val;
  } code_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int fail_count;
  int bytes_waiting;
  int bytes_seen;
  int cycle_cnt = 0;

  // receiver hold-off handshake between stimulus and receiver
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  code_item_t codes_q[$];

  msb_first_bit_packer_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  mbp_stream_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .fail_count_o    (fail_count),
    .bytes_waiting_o (bytes_waiting),
    .bytes_seen_o    (bytes_seen)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("msb_first_bit_packer_top regression: fail");
    $finish;
  end

  task automatic queue_code(input func_e func, input logic [5:0] len, input logic [31:0] val);
    code_item_t it;
    it.func = func;
    it.len  = len;
    it.val  = val;
    codes_q.push_back(it);
  endtask

  // Receiver: spans of different stall patterns, plus one long hold-off
  initial begin
    int mode;
    int span;
    int tick;
    m_axis_tready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (hold_req && !hold_done) begin
          // long stall so the queue fills and the input backs up
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_done = 1'b1;
        end else begin
          case (mode)
            0: begin
              m_axis_tready <= 1'b1;
            end
            1: begin
              m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
              m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
              m_axis_tready <= ((tick % 5) != 4);
            end
          endcase
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    code_item_t it;
    int         n_directed;
    int         idx;
    int         burst;
    int         gap;
    int         r;
    int         n_flush;
    int         n_over;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_n         = 1'b0;
    n_flush       = 0;
    n_over        = 0;

    // Directed codes: length extremes, saturation, flush corners
    queue_code(FUNC_PUT,   6'd0,  32'hFFFF_FFFF);  // empty code on a boundary
    queue_code(FUNC_FLUSH, 6'd0,  32'h0);          // flush on a boundary
    queue_code(FUNC_PUT,   6'd1,  32'h0000_0001);
    queue_code(FUNC_PUT,   6'd0,  32'h1234_5678);  // empty code with bits pending
    queue_code(FUNC_FLUSH, 6'd63, 32'hFFFF_FFFF);  // flush ignores its fields
    queue_code(FUNC_PUT,   6'd8,  32'hFFFF_FFA5);
    queue_code(FUNC_PUT,   6'd32, 32'hFFFF_FFFF);
    queue_code(FUNC_PUT,   6'd32, 32'h0000_0000);
    queue_code(FUNC_PUT,   6'd7,  32'h0000_007F);
    queue_code(FUNC_PUT,   6'd32, 32'h8000_0001);  // seven pending plus 32: four bytes
    queue_code(FUNC_FLUSH, 6'd21, 32'hDEAD_BEEF);
    queue_code(FUNC_FLUSH, 6'd0,  32'h0);          // second flush emits nothing
    queue_code(FUNC_PUT,   6'd33, 32'hAAAA_AAAA);  // saturates to 32
    queue_code(FUNC_PUT,   6'd3,  32'h0000_0005);
    queue_code(FUNC_PUT,   6'd63, 32'h5555_5555);  // saturates to 32
    queue_code(FUNC_PUT,   6'd40, 32'hC3C3_C3C3);
    queue_code(FUNC_PUT,   6'd31, 32'h7FFF_FFFF);
    queue_code(FUNC_PUT,   6'd1,  32'hFFFF_FFFE);
    queue_code(FUNC_FLUSH, 6'd32, 32'h0);
    queue_code(FUNC_PUT,   6'd16, 32'h0000_BEEF);
    queue_code(FUNC_PUT,   6'd5,  32'h0000_0011);
    queue_code(FUNC_FLUSH, 6'd0,  32'h0);
    n_directed = codes_q.size();

    // Random codes: mostly legal lengths, some flushes, zeros and overlong lengths
    repeat (N_RANDOM) begin
      r       = $urandom_range(0, 99);
      it.val  = $urandom();
      it.len  = 6'($urandom());
      if (r < 12) begin
        it.func = FUNC_FLUSH;
      end else begin
        it.func = FUNC_PUT;
        case ($urandom_range(0, 9))
          0:       it.len = 6'd0;
          1:       it.len = 6'd32;
          2:       it.len = 6'($urandom_range(33, 63));
          3:       it.len = 6'($urandom_range(1, 8));
          default: it.len = 6'($urandom_range(1, 32));
        endcase
      end
      codes_q.push_back(it);
    end
    foreach (codes_q[i]) begin
      if (codes_q[i].func == FUNC_FLUSH) n_flush++;
      else if (codes_q[i].len > 6'd32) n_over++;
    end

    // Hold reset, then release it on a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Send beats in bursts with random gaps
    idx = 0;
    while (idx < codes_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < codes_q.size()) begin
        if (idx == n_directed) hold_req = 1'b1;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, codes_q[idx].val, codes_q[idx].len};
        s_axis_tuser  <= codes_q[idx].func;
        do @(posedge clk); while (!s_axis_tready);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // Drain, then keep watching for anything unexpected
    while (bytes_waiting != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d code beats (%0d flushes, %0d overlong lengths), one long receiver stall.",
             codes_q.size(), n_flush, n_over);
    $display("Checked %0d output bytes in %0d cycles.", bytes_seen, cycle_cnt);
    if (fail_count == 0 && bytes_waiting == 0) begin
      $display("msb_first_bit_packer_top regression: pass");
    end else begin
      $display("msb_first_bit_packer_top regression: fail");
    end
    $finish;
  end

endmodule
